>>> rtl/core/sbi_pkg.sv
// Shared types for the segment/box intersection block.
package sbi_pkg;

  // Per-axis direction flags carried between the pipeline stages.
  typedef struct packed {
    logic zero_dir; // direction component is zero on this axis
    logic out_slab; // zero direction and start outside the slab
  } axis_flags_t;

endpackage

>>> rtl/core/sbi_if.sv
// Valid/ready channel interfaces for the segment/box intersection block.
interface sbi_in_if #(
  parameter int COORD_BITS = 16
);
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic signed [COORD_BITS-1:0] box_origin_x;
  logic signed [COORD_BITS-1:0] box_origin_y;
  logic signed [COORD_BITS-1:0] box_size_x;
  logic signed [COORD_BITS-1:0] box_size_y;
  modport source (output valid, start_x, start_y, end_x, end_y, box_origin_x,
                  box_origin_y, box_size_x, box_size_y, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, box_origin_x,
                box_origin_y, box_size_x, box_size_y, output ready);
endinterface

interface sbi_out_if;
  logic valid;
  logic ready;
  logic hit;
  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

>>> rtl/core/segment_box_intersect.sv
// Segment versus axis-aligned box hit test, pipelined at one item a cycle while out is not stalled.
//
// Channels: in (sink) carries one segment and one box per item; out
// (source) carries one hit bit per item, in input order.
// The five stages are bounds, slab fractions, cross-multiply, select and
// cross-multiply; an accepted item shows on out after passing them in
// order. Throughput: one item per cycle when out is not stalled.
// Each stage multiplies at most once per product path (18 by 18 bits at
// the default width), with a register after every multiplication.
// When out is stalled with a valid item, that item holds and the stages
// before it keep loading until each holds an item; only then in.ready
// drops. A bubble anywhere is squeezed out since a stage may load
// whenever the one after it moves.
// Reset clears all valid bits; payload registers are not reset.
module segment_box_intersect
  import sbi_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input logic clk,
  input logic rst,
  sbi_in_if.sink in,
  sbi_out_if.source out
);

  localparam int CW = COORD_BITS;     // coordinate
  localparam int BW = COORD_BITS + 1; // box corner
  localparam int NW = COORD_BITS + 2; // fraction numerator / denominator
  localparam int PW = 2 * NW;         // cross product

  typedef logic signed [CW-1:0] crd_t;
  typedef logic signed [BW-1:0] bnd_t;
  typedef logic signed [NW-1:0] num_t;
  typedef logic signed [PW-1:0] prd_t;

  logic [4:0] vld;
  logic [4:0] adv;

  // Stage 0 registers: box corners and endpoints.
  crd_t sx0, sy0, ex0, ey0;
  bnd_t lox0, hix0, loy0, hiy0;
  // Stage 1: fractions per axis.
  logic inside1;
  axis_flags_t fx1, fy1;
  num_t ax1, bx1, dx1, ay1, by1, dy1;
  // Stage 2: cross products for entry/exit choice.
  logic inside2;
  axis_flags_t fx2, fy2;
  num_t ax2, bx2, dx2, ay2, by2, dy2;
  prd_t p_ay_dx2, p_ax_dy2, p_by_dx2, p_bx_dy2;
  // Stage 3: chosen entry and exit.
  logic inside3, miss3;
  num_t en3, ed3, ln3, ld3;
  // Stage 4: entry versus exit cross products.
  logic inside4, miss4;
  num_t en4, ed4, ln4, ld4;
  prd_t p_el4, p_le4;
  logic hit4;

  assign adv[4] = !vld[4] || out.ready;
  assign adv[3] = !vld[3] || adv[4];
  assign adv[2] = !vld[2] || adv[3];
  assign adv[1] = !vld[1] || adv[2];
  assign adv[0] = !vld[0] || adv[1];
  assign in.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in.valid;
      if (adv[1]) vld[1] <= vld[0];
      if (adv[2]) vld[2] <= vld[1];
      if (adv[3]) vld[3] <= vld[2];
      if (adv[4]) vld[4] <= vld[3];
    end
  end

  // Stage 0: corners at one extra bit.
  bnd_t px, py, ox, oy;
  always_comb begin
    ox = BW'(in.box_origin_x);
    oy = BW'(in.box_origin_y);
    px = ox + BW'(in.box_size_x);
    py = oy + BW'(in.box_size_y);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      sx0 <= in.start_x;
      sy0 <= in.start_y;
      ex0 <= in.end_x;
      ey0 <= in.end_y;
      lox0 <= (ox < px) ? ox : px;
      hix0 <= (ox < px) ? px : ox;
      loy0 <= (oy < py) ? oy : py;
      hiy0 <= (oy < py) ? py : oy;
    end
  end

  // Stage 1: endpoint test and slab fractions.
  num_t sxn, syn, exn, eyn, dxr, dyr;
  num_t lxn, hxn, lyn, hyn;
  logic s_in, e_in;
  always_comb begin
    sxn = NW'(sx0);
    syn = NW'(sy0);
    exn = NW'(ex0);
    eyn = NW'(ey0);
    lxn = NW'(lox0);
    hxn = NW'(hix0);
    lyn = NW'(loy0);
    hyn = NW'(hiy0);
    dxr = exn - sxn;
    dyr = eyn - syn;
    s_in = lxn <= sxn && sxn <= hxn && lyn <= syn && syn <= hyn;
    e_in = lxn <= exn && exn <= hxn && lyn <= eyn && eyn <= hyn;
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      inside1 <= s_in || e_in;
      fx1.zero_dir <= dxr == '0;
      fx1.out_slab <= dxr == '0 && (sxn < lxn || sxn > hxn);
      fy1.zero_dir <= dyr == '0;
      fy1.out_slab <= dyr == '0 && (syn < lyn || syn > hyn);
      if (!dxr[NW-1]) begin
        ax1 <= lxn - sxn;
        bx1 <= hxn - sxn;
        dx1 <= dxr;
      end else begin
        ax1 <= sxn - hxn;
        bx1 <= sxn - lxn;
        dx1 <= -dxr;
      end
      if (!dyr[NW-1]) begin
        ay1 <= lyn - syn;
        by1 <= hyn - syn;
        dy1 <= dyr;
      end else begin
        ay1 <= syn - hyn;
        by1 <= syn - lyn;
        dy1 <= -dyr;
      end
    end
  end

  // Stage 2: cross products comparing y fractions against x fractions.
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      inside2 <= inside1;
      fx2 <= fx1;
      fy2 <= fy1;
      ax2 <= ax1;
      bx2 <= bx1;
      dx2 <= dx1;
      ay2 <= ay1;
      by2 <= by1;
      dy2 <= dy1;
      p_ay_dx2 <= PW'(ay1) * PW'(dx1);
      p_ax_dy2 <= PW'(ax1) * PW'(dy1);
      p_by_dx2 <= PW'(by1) * PW'(dx1);
      p_bx_dy2 <= PW'(bx1) * PW'(dy1);
    end
  end

  // Stage 3: pick entry and exit over the axes that limit.
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      inside3 <= inside2;
      miss3 <= fx2.out_slab || fy2.out_slab || (fx2.zero_dir && fy2.zero_dir);
      if (fx2.zero_dir) begin
        en3 <= ay2; ed3 <= dy2; ln3 <= by2; ld3 <= dy2;
      end else if (fy2.zero_dir) begin
        en3 <= ax2; ed3 <= dx2; ln3 <= bx2; ld3 <= dx2;
      end else begin
        if (p_ay_dx2 > p_ax_dy2) begin
          en3 <= ay2; ed3 <= dy2;
        end else begin
          en3 <= ax2; ed3 <= dx2;
        end
        if (p_by_dx2 < p_bx_dy2) begin
          ln3 <= by2; ld3 <= dy2;
        end else begin
          ln3 <= bx2; ld3 <= dx2;
        end
      end
    end
  end

  // Stage 4: entry versus exit.
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      inside4 <= inside3;
      miss4 <= miss3;
      en4 <= en3;
      ed4 <= ed3;
      ln4 <= ln3;
      ld4 <= ld3;
      p_el4 <= PW'(en3) * PW'(ld3);
      p_le4 <= PW'(ln3) * PW'(ed3);
    end
  end

  num_t tn, td;
  always_comb begin
    tn = en4[NW-1] ? ln4 : en4;
    td = en4[NW-1] ? ld4 : ed4;
    hit4 = inside4 || (!miss4 && !ln4[NW-1] && !(p_el4 > p_le4) &&
           tn > '0 && tn < td);
  end

  assign out.valid = vld[4];
  assign out.hit = hit4;

`ifndef SYNTH
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid && $stable(out.hit))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in.ready |-> vld[0] && vld[4] && !out.ready)
    else $error("input stalled without a full stalled pipe");
  a_move: assert property (@(posedge clk) disable iff (rst)
    vld[3] && adv[4] |=> vld[4])
    else $error("item lost between final stages");
  a_inside: assert property (@(posedge clk) disable iff (rst)
    vld[4] && inside4 |-> out.hit)
    else $error("endpoint inside but no hit");
`endif

endmodule

>>> sim/sbi_scoreboard.sv
// Hit predictor and in-order checker for the segment/box intersection testbench.
`timescale 1ns / 100ps

class sbi_scoreboard;
  bit hits_pending[$];
  int errors;

  // Exact hit test; all arithmetic fits easily in 64 bits at 16-bit coordinates.
  static function bit predict_hit(logic signed [15:0] sx, logic signed [15:0] sy,
                                  logic signed [15:0] ex, logic signed [15:0] ey,
                                  logic signed [15:0] ox, logic signed [15:0] oy,
                                  logic signed [15:0] wx, logic signed [15:0] wy);
    longint s[2], e[2], lo[2], hi[2], o, p, d, an, bn, dn;
    longint en_n, en_d, lv_n, lv_d, t_n, t_d;
    bit have;
    s[0] = sx; s[1] = sy; e[0] = ex; e[1] = ey;
    o = ox; p = o + wx;
    lo[0] = (o < p) ? o : p; hi[0] = (o < p) ? p : o;
    o = oy; p = o + wy;
    lo[1] = (o < p) ? o : p; hi[1] = (o < p) ? p : o;
    if ((lo[0] <= s[0] && s[0] <= hi[0] && lo[1] <= s[1] && s[1] <= hi[1]) ||
        (lo[0] <= e[0] && e[0] <= hi[0] && lo[1] <= e[1] && e[1] <= hi[1]))
      return 1;
    have = 0;
    en_n = 0; en_d = 1; lv_n = 0; lv_d = 1;
    for (int ax = 0; ax < 2; ax++) begin
      d = e[ax] - s[ax];
      if (d == 0) begin
        if (s[ax] < lo[ax] || s[ax] > hi[ax]) return 0;
        continue;
      end
      if (d > 0) begin
        an = lo[ax] - s[ax]; bn = hi[ax] - s[ax]; dn = d;
      end else begin
        an = s[ax] - hi[ax]; bn = s[ax] - lo[ax]; dn = -d;
      end
      if (!have) begin
        en_n = an; en_d = dn; lv_n = bn; lv_d = dn; have = 1;
      end else begin
        if (an * en_d > en_n * dn) begin en_n = an; en_d = dn; end
        if (bn * lv_d < lv_n * dn) begin lv_n = bn; lv_d = dn; end
      end
    end
    if (!have) return 0;
    if (lv_n < 0 || en_n * lv_d > lv_n * en_d) return 0;
    if (en_n < 0) begin t_n = lv_n; t_d = lv_d; end
    else begin t_n = en_n; t_d = en_d; end
    return (t_n > 0 && t_n < t_d);
  endfunction

  function void note_segment(logic signed [15:0] f[8]);
    hits_pending.push_back(predict_hit(f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7]));
  endfunction

  task report(string msg);
    $display("ERROR %0t: %s", $time, msg);
    errors++;
  endtask

  task check_hit(logic h);
    bit want;
    if (hits_pending.size() == 0) begin
      report("result with no item outstanding");
    end else begin
      want = hits_pending.pop_front();
      if (h !== want) report($sformatf("hit %b, predicted %b", h, want));
    end
  endtask
endclass

>>> sim/testbench.sv
// Top-level testbench for segment_box_intersect.
`timescale 1ns / 100ps

module testbench;
  logic clk, rst;
  sbi_in_if #(.COORD_BITS(16)) in_ch();
  sbi_out_if out_ch();
  sbi_scoreboard sb;
  int idle_cycles;
  int stall_phase;
  bit stim_done;

  segment_box_intersect #(.COORD_BITS(16)) DUT (
    .clk(clk), .rst(rst), .in(in_ch.sink), .out(out_ch.source)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    sb = new();
    in_ch.valid = 0;
    {in_ch.start_x, in_ch.start_y, in_ch.end_x, in_ch.end_y} = '0;
    {in_ch.box_origin_x, in_ch.box_origin_y, in_ch.box_size_x, in_ch.box_size_y} = '0;
    out_ch.ready = 0;
    rst = 1;
    repeat (6) @(posedge clk);
    rst <= 0;
  end

  // Receiver stalls in a repeating pattern with random extra ready cycles and periodic phases of no stall.
  always @(posedge clk) begin
    if (rst) begin
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[8]) out_ch.ready <= 1;
      else out_ch.ready <= (stall_phase % 7 < 4) || ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) sb.check_hit(out_ch.hit);
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic logic signed [15:0] rand_coord(int mode);
    case (mode)
      0: return 16'($urandom());
      1: return 16'($urandom_range(0, 40) - 20);
      default: return 16'($urandom_range(0, 400) - 200);
    endcase
  endfunction

  // Drive one item and hold it until accepted; valid stays high for back-to-back items.
  task send_segment(logic signed [15:0] f[8], bit last_in_burst);
    in_ch.valid <= 1;
    {in_ch.start_x, in_ch.start_y, in_ch.end_x, in_ch.end_y} <= {f[0], f[1], f[2], f[3]};
    {in_ch.box_origin_x, in_ch.box_origin_y, in_ch.box_size_x, in_ch.box_size_y}
      <= {f[4], f[5], f[6], f[7]};
    do @(posedge clk); while (!in_ch.ready);
    sb.note_segment(f);
    if (last_in_burst) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
  endtask

  task automatic send_directed();
    logic signed [15:0] d[24][8] = '{
      '{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 0, 0, 1, 1},
      '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
        16'sd32767, 16'sd32767},
      '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
        -16'sd32768, -16'sd32768, -16'sd32768},
      '{-10, 5, 10, 5, 0, 0, 3, 8},      // crosses box, zero y direction inside slab
      '{-10, 20, 10, 20, 0, 0, 3, 8},    // zero y direction outside slab
      '{5, -10, 5, 10, 0, 0, 8, 3},      // zero x direction inside slab
      '{20, -10, 20, 10, 0, 0, 8, 3},
      '{1, 1, 1, 1, 0, 0, 3, 3},         // point inside
      '{9, 9, 9, 9, 0, 0, 3, 3},         // point outside
      '{3, 3, 9, 9, 0, 0, 3, 3},         // start on corner
      '{-5, 0, 0, -5, 0, 0, 3, 3},       // diagonal that passes outside corner (0,0)
      '{-5, 3, 10, 3, 0, 0, 3, 3},       // slides along a face
      '{-4, 4, 4, -4, 0, 0, 3, 3},       // touches only corner (0,0) at t=0.5
      '{-5, -1, 5, -1, 0, 0, 3, 3},
      '{10, 10, -10, -10, 2, 2, -4, -4}, // negative size
      '{-10, 10, 10, -10, 3, 3, -6, -6},
      '{-10, -3, 10, 7, 0, 0, 2, 2},
      '{-32768, 0, 32767, 0, 32767, -5, 16'sd32767, 10},
      '{0, -32768, 0, 32767, -32768, -32768, -16'sd32768, 10},
      '{100, 100, 200, 200, 0, 0, 50, 50},
      '{-100, -100, -50, -50, 0, 0, 50, 50},
      '{0, 7, 7, 0, 0, 0, 3, 3},
      '{-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1},
      '{16'sd21845, -16'sd21846, -16'sd21846, 16'sd21845, 16'sd21845, -16'sd21846,
        -16'sd21846, 16'sd21845}
    };
    for (int i = 0; i < 24; i++) send_segment(d[i], i == 23);
  endtask

  initial begin
    logic signed [15:0] f[8];
    int sent, burst, mode;
    stim_done = 0;
    @(negedge rst);
    @(posedge clk);
    send_directed();
    sent = 0;
    while (sent < 400) begin
      burst = $urandom_range(1, 20);
      mode = $urandom_range(0, 3);
      for (int b = 0; b < burst; b++) begin
        for (int k = 0; k < 8; k++) f[k] = rand_coord(mode);
        // Often pin an axis to zero direction.
        if ($urandom_range(0, 7) == 0) f[2] = f[0];
        if ($urandom_range(0, 7) == 0) f[3] = f[1];
        send_segment(f, b == burst - 1);
        sent++;
      end
      // Hold off until the pipeline has drained, once per run.
      if (sent > 200 && sent - burst <= 200)
        while (sb.hits_pending.size() != 0) @(posedge clk);
      repeat ($urandom_range(0, 6)) @(posedge clk);
    end
    while (sb.hits_pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
